[rtl/ibps_pkg.sv]
// Types, pattern tables and next-state functions of the indicator blink pattern sequencer.
package ibps_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t MODE_PERMANENT = 8'd251;
  localparam byte_t MODE_REPEAT    = 8'd252;
  localparam byte_t MODE_ONCE      = 8'd253;
  localparam byte_t MODE_ON        = 8'd254;
  localparam byte_t MODE_OFF       = 8'd255;
  localparam byte_t MARK_END       = 8'd0;

  localparam int unsigned TABLE_ROWS = 21;
  localparam int unsigned TABLE_COLS = 24;

  localparam byte_t TICK_DIVIDE_RST = 8'd10;

  typedef logic [TABLE_COLS-1:0][7:0] row_t;

  // Per-channel sequencer state.
  typedef struct packed {
    logic [4:0] base;
    logic [4:0] overlay;
    logic [4:0] pos;
    logic [7:0] ticks;
    logic       level;
  } chan_t;

  // Builds one pattern row; unlisted slots are end marks.
  function automatic row_t mk(
    input byte_t e0, input byte_t e1 = 8'd0, input byte_t e2 = 8'd0,
    input byte_t e3 = 8'd0, input byte_t e4 = 8'd0, input byte_t e5 = 8'd0,
    input byte_t e6 = 8'd0, input byte_t e7 = 8'd0, input byte_t e8 = 8'd0,
    input byte_t e9 = 8'd0, input byte_t e10 = 8'd0, input byte_t e11 = 8'd0,
    input byte_t e12 = 8'd0, input byte_t e13 = 8'd0, input byte_t e14 = 8'd0,
    input byte_t e15 = 8'd0, input byte_t e16 = 8'd0, input byte_t e17 = 8'd0,
    input byte_t e18 = 8'd0, input byte_t e19 = 8'd0, input byte_t e20 = 8'd0);
    row_t r;
    r = '0;
    r[0] = e0;   r[1] = e1;   r[2] = e2;   r[3] = e3;   r[4] = e4;
    r[5] = e5;   r[6] = e6;   r[7] = e7;   r[8] = e8;   r[9] = e9;
    r[10] = e10; r[11] = e11; r[12] = e12; r[13] = e13; r[14] = e14;
    r[15] = e15; r[16] = e16; r[17] = e17; r[18] = e18; r[19] = e19;
    r[20] = e20;
    return r;
  endfunction

  localparam row_t LED_PAT [TABLE_ROWS] = '{
    mk(MODE_OFF),
    mk(MODE_REPEAT, 8'd7, 8'd1, 8'd1, 8'd1),
    mk(MODE_ONCE, 8'd15, 8'd1, 8'd10),
    mk(MODE_ONCE, 8'd15, 8'd1, 8'd1, 8'd1, 8'd10),
    mk(MODE_ONCE, 8'd15, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd10),
    mk(MODE_ONCE, 8'd15, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
       8'd1, 8'd10),
    mk(MODE_ONCE, 8'd15, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
       8'd1, 8'd10),
    mk(MODE_ONCE, 8'd15, 8'd1, 8'd1, 8'd1, 8'd1, 8'd5, 8'd1, 8'd1, 8'd10),
    mk(MODE_ONCE, 8'd15, 8'd1, 8'd1, 8'd1, 8'd1, 8'd5, 8'd1, 8'd5, 8'd1, 8'd1, 8'd10),
    mk(MODE_REPEAT, 8'd5, 8'd1, 8'd1, 8'd5, 8'd1, 8'd5),
    mk(MODE_REPEAT, 8'd5, 8'd1, 8'd1, 8'd5, 8'd1, 8'd5),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
       8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1),
    mk(MODE_REPEAT, 8'd5, 8'd5),
    mk(MODE_ON),
    mk(MODE_OFF),
    mk(MODE_PERMANENT, 8'd9, 8'd1),
    mk(MODE_PERMANENT, 8'd1, 8'd1, 8'd3, 8'd1),
    mk(MODE_PERMANENT, 8'd1, 8'd1),
    mk(MODE_PERMANENT, 8'd1, 8'd1),
    mk(MODE_ONCE, 8'd15, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd10),
    mk(MODE_PERMANENT, 8'd2, 8'd2)
  };

  localparam row_t BUZ_PAT [TABLE_ROWS] = '{
    mk(MODE_OFF),
    mk(MODE_OFF),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd7),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd7),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd5, 8'd1, 8'd1, 8'd10),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd5, 8'd1, 8'd5, 8'd1, 8'd1, 8'd10),
    mk(MODE_REPEAT, 8'd5, 8'd1, 8'd1, 8'd5, 8'd1, 8'd5),
    mk(MODE_REPEAT, 8'd5, 8'd1, 8'd1, 8'd5, 8'd1, 8'd5),
    mk(MODE_ONCE, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
       8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1),
    mk(MODE_OFF),
    mk(MODE_OFF),
    mk(MODE_OFF),
    mk(MODE_PERMANENT, 8'd9, 8'd1),
    mk(MODE_PERMANENT, 8'd1, 8'd1, 8'd3, 8'd1),
    mk(MODE_PERMANENT, 8'd1, 8'd1),
    mk(MODE_PERMANENT, 8'd1, 8'd1),
    mk(MODE_ONCE, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd6),
    mk(MODE_PERMANENT, 8'd2, 8'd2)
  };

  function automatic logic status_ok(input logic [4:0] st, input int unsigned scount);
    return (32'(st) < scount) && (32'(st) < TABLE_ROWS);
  endfunction

  // Table read: bad status reads as an off pattern, slots past the end as end marks.
  function automatic byte_t pat_entry(input logic ch, input logic [4:0] st,
                                      input logic [4:0] pos, input int unsigned scount,
                                      input int unsigned slots);
    byte_t v;
    v = MARK_END;
    if (!status_ok(st, scount)) begin
      if (pos == 5'd0) v = MODE_OFF;
    end else if ((32'(pos) < slots) && (32'(pos) < TABLE_COLS)) begin
      v = ch ? BUZ_PAT[st][pos] : LED_PAT[st][pos];
    end
    return v;
  endfunction

  function automatic chan_t set_status(input logic ch, input logic [4:0] st,
                                       input logic force_load, input chan_t c,
                                       input int unsigned scount,
                                       input int unsigned slots);
    chan_t r;
    byte_t mode;
    logic  fresh;
    r     = c;
    mode  = pat_entry(ch, st, 5'd0, scount, slots);
    fresh = 1'b0;
    // permanent base only yields to another permanent status
    if (pat_entry(ch, c.base, 5'd0, scount, slots) == MODE_PERMANENT &&
        mode != MODE_PERMANENT) return r;
    if (st == 5'd0) begin
      r.base    = 5'd0;
      r.overlay = 5'd0;
      return r;
    end
    if (mode == MODE_ONCE) begin
      if (r.overlay != st) begin
        r.overlay = st;
        fresh     = 1'b1;
      end
    end else begin
      if (r.overlay == 5'd0 && r.base != st) fresh = 1'b1;
      r.base = st;
    end
    if (!(fresh || force_load)) return r;
    if (mode == MODE_OFF || mode == MODE_ON) begin
      r.pos   = 5'd0;
      r.ticks = 8'd0;
      r.level = (mode == MODE_ON);
    end else begin
      r.pos   = 5'd1;
      r.ticks = pat_entry(ch, st, 5'd1, scount, slots);
      r.level = 1'b0;
    end
    return r;
  endfunction

  function automatic chan_t advance(input logic ch, input chan_t c,
                                    input int unsigned scount, input int unsigned slots);
    chan_t      r;
    logic [4:0] cur;
    byte_t      nxt;
    r   = c;
    cur = (c.overlay != 5'd0) ? c.overlay : c.base;
    if (c.pos == 5'd0 || cur == 5'd0) return r;
    r.ticks = c.ticks - 8'd1;
    if (r.ticks != 8'd0) return r;
    r.pos = c.pos + 5'd1;
    nxt   = pat_entry(ch, cur, r.pos, scount, slots);
    if (nxt == MARK_END) begin
      // pattern done: drop overlay, restart base pattern
      r.overlay = 5'd0;
      r = set_status(ch, r.base, 1'b1, r, scount, slots);
    end else begin
      r.ticks = nxt;
      r.level = ~r.pos[0];
    end
    return r;
  endfunction

endpackage

[rtl/ibps_if.sv]
// Valid/ready channel interfaces for input events and output levels.
interface ibps_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [4:0] status_code;

  modport source (output valid, output cmd, output status_code, input ready);
  modport sink   (input valid, input cmd, input status_code, output ready);
endinterface

interface ibps_out_if;
  logic valid;
  logic ready;
  logic led_on;
  logic buzzer_on;

  modport source (output valid, output led_on, output buzzer_on, input ready);
  modport sink   (input valid, input led_on, input buzzer_on, output ready);
endinterface

[rtl/indicator_blink_pattern_sequencer.sv]
// Top level: two-channel LED/buzzer blink pattern sequencer.
// Each input beat is either a base tick (cmd = 0) or a new status (cmd = 1).
// Ticks go through a prescaler of tick_divide; when it rolls over, both channels
// advance one tick. A status beat clears the prescaler and loads the status into
// both channels (out-of-range codes leave channels unchanged). Every input beat
// produces exactly one output beat carrying the LED and buzzer levels after that
// event. Throughput is one beat per clock unless the output stalls. A beat waits
// in the input register, then the single-pass next-state logic (table lookups
// and compares) writes channel state and the output register together. Both
// sides may stall freely. tick_divide is written via cfg_we/cfg_wdata; the user
// must do so only while no beat is in flight (unchecked). Zero acts as one.
module indicator_blink_pattern_sequencer #(
  parameter int unsigned STATUS_COUNT  = 21,
  parameter int unsigned PATTERN_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  ibps_in_if.sink             item,
  ibps_out_if.source          result
);
  import ibps_pkg::*;

  // config
  logic [7:0] tick_divide;

  // input register
  logic       in_v;
  logic       in_cmd;
  logic [4:0] in_code;

  // output register
  logic       out_v;
  logic       out_led;
  logic       out_buz;

  // sequencer state
  logic [7:0] prescale;
  logic [7:0] prescale_next;
  chan_t      chan      [2];
  chan_t      chan_next [2];

  logic       fire;
  logic [7:0] prescale_inc;

  // process the held beat when the output register is free or draining
  assign fire       = in_v && (!out_v || result.ready);
  assign item.ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide <= TICK_DIVIDE_RST;
    end else if (cfg_we) begin
      tick_divide <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_cmd  <= item.cmd;
      in_code <= item.status_code;
    end
  end

  assign prescale_inc = prescale + 8'd1;

  // single-pass next state for one beat
  always_comb begin
    prescale_next = prescale;
    chan_next[0]  = chan[0];
    chan_next[1]  = chan[1];
    if (!in_cmd) begin
      prescale_next = prescale_inc;
      if (prescale_inc >= tick_divide) begin
        prescale_next = 8'd0;
        chan_next[0]  = advance(1'b0, chan[0], STATUS_COUNT, PATTERN_SLOTS);
        chan_next[1]  = advance(1'b1, chan[1], STATUS_COUNT, PATTERN_SLOTS);
      end
    end else begin
      prescale_next = 8'd0;
      if (status_ok(in_code, STATUS_COUNT)) begin
        chan_next[0] = set_status(1'b0, in_code, 1'b0, chan[0], STATUS_COUNT, PATTERN_SLOTS);
        chan_next[1] = set_status(1'b1, in_code, 1'b0, chan[1], STATUS_COUNT, PATTERN_SLOTS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= 8'd0;
      chan[0]  <= '0;
      chan[1]  <= '0;
    end else if (fire) begin
      prescale <= prescale_next;
      chan[0]  <= chan_next[0];
      chan[1]  <= chan_next[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_led <= chan_next[0].level;
      out_buz <= chan_next[1].level;
    end
  end

  assign result.valid     = out_v;
  assign result.led_on    = out_led;
  assign result.buzzer_on = out_buz;

  // a status beat always restarts the prescaler
  a_cmd_clears_prescale: assert property (@(posedge clk) disable iff (rst)
    fire && in_cmd |=> prescale == 8'd0)
    else $error("prescaler not cleared by status beat");

  // a pending output beat always reflects the current channel levels
  a_out_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_led == chan[0].level) && (out_buz == chan[1].level))
    else $error("output beat out of step with channel state");

  // an overlay is only ever a once pattern
  a_led_overlay_once: assert property (@(posedge clk) disable iff (rst)
    chan[0].overlay != 5'd0 |->
      pat_entry(1'b0, chan[0].overlay, 5'd0, STATUS_COUNT, PATTERN_SLOTS) == MODE_ONCE)
    else $error("LED overlay is not a once pattern");

  a_buz_overlay_once: assert property (@(posedge clk) disable iff (rst)
    chan[1].overlay != 5'd0 |->
      pat_entry(1'b1, chan[1].overlay, 5'd0, STATUS_COUNT, PATTERN_SLOTS) == MODE_ONCE)
    else $error("buzzer overlay is not a once pattern");

endmodule

[sim/tb.sv]
// Testbench for the indicator blink pattern sequencer: scripted and random beats vs. a predictor.
module tb;
  import ibps_pkg::*;

  // Status codes at and above this count are rejected by the block.
  localparam int STATUS_TOTAL = 21;
  localparam logic [7:0] DIVIDE_AT_RESET = 8'd10;
  // Margin waited after the last output beat, before a register write or the end.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  ibps_in_if in_ch ();
  ibps_out_if out_ch ();

  indicator_blink_pattern_sequencer #(
    .STATUS_COUNT(STATUS_TOTAL),
    .PATTERN_SLOTS(32)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .item(in_ch),
    .result(out_ch)
  );

  // ---------------------------------------------------------------------------
  // Pattern tables, kept independently of the design. Slot 0 is the mode; the
  // step durations follow, one hex digit each (all durations fit in 1..15).
  // A slot past the end of a string reads as the end mark.
  // ---------------------------------------------------------------------------
  byte_t led_mode [STATUS_TOTAL] = '{
    MODE_OFF, MODE_REPEAT, MODE_ONCE, MODE_ONCE, MODE_ONCE, MODE_ONCE, MODE_ONCE,
    MODE_ONCE, MODE_ONCE, MODE_REPEAT, MODE_REPEAT, MODE_ONCE, MODE_REPEAT, MODE_ON,
    MODE_OFF, MODE_PERMANENT, MODE_PERMANENT, MODE_PERMANENT, MODE_PERMANENT,
    MODE_ONCE, MODE_PERMANENT
  };
  byte_t buz_mode [STATUS_TOTAL] = '{
    MODE_OFF, MODE_OFF, MODE_ONCE, MODE_ONCE, MODE_ONCE, MODE_ONCE, MODE_ONCE,
    MODE_ONCE, MODE_ONCE, MODE_REPEAT, MODE_REPEAT, MODE_ONCE, MODE_OFF, MODE_OFF,
    MODE_OFF, MODE_PERMANENT, MODE_PERMANENT, MODE_PERMANENT, MODE_PERMANENT,
    MODE_ONCE, MODE_PERMANENT
  };
  string led_steps [STATUS_TOTAL] = '{
    "", "7111", "f1a", "f111a", "f11111a", "f11111111111a", "f11111111111a",
    "f1111511a", "f111151511a", "511515", "511515", "11111111111111111111", "55",
    "", "", "91", "1131", "11", "11", "f2222222a", "22"
  };
  string buz_steps [STATUS_TOTAL] = '{
    "", "", "111", "11111", "1111111", "11111111117", "11111111117",
    "11111511a", "1111151511a", "511515", "511515", "11111111111111111111", "",
    "", "", "91", "1131", "11", "11", "222222226", "22"
  };

  // ---------------------------------------------------------------------------
  // Predictor state: one record per channel (0 = LED, 1 = buzzer).
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [4:0] base;
    logic [4:0] overlay;  // 0 = no once pattern on top
    logic [4:0] pos;      // 0 = steady level, no stepping
    logic [7:0] ticks;
    logic       level;
  } chan_state_t;

  typedef struct packed {
    logic led;
    logic buz;
  } levels_t;

  chan_state_t chan [2];
  logic [7:0] divide_q;
  logic [7:0] prescale_q;

  levels_t pending_levels [$];
  bit failed;

  function automatic byte_t pattern_byte(input int ch, input logic [4:0] st,
                                         input logic [4:0] pos);
    string durs;
    logic [7:0] c;
    // unknown status plays as an empty off pattern
    if (int'(st) >= STATUS_TOTAL) return (pos == 5'd0) ? MODE_OFF : MARK_END;
    if (pos == 5'd0) return ch ? buz_mode[st] : led_mode[st];
    durs = ch ? buz_steps[st] : led_steps[st];
    if (int'(pos) > durs.len()) return MARK_END;
    c = durs[pos - 1];
    return (c >= "a") ? c - "a" + 8'd10 : c - "0";
  endfunction

  function automatic void load_status(input int ch, input logic [4:0] st,
                                      input bit force_load);
    byte_t mode;
    bit fresh;
    mode = pattern_byte(ch, st, 5'd0);
    fresh = 1'b0;
    // a permanent base only gives way to another permanent status
    if (pattern_byte(ch, chan[ch].base, 5'd0) == MODE_PERMANENT && mode != MODE_PERMANENT)
      return;
    if (st == 5'd0) begin
      // none: drop both, level and position stay put
      chan[ch].base = 5'd0;
      chan[ch].overlay = 5'd0;
      return;
    end
    if (mode == MODE_ONCE) begin
      if (chan[ch].overlay != st) begin
        chan[ch].overlay = st;
        fresh = 1'b1;
      end
    end else begin
      if (chan[ch].overlay == 5'd0 && chan[ch].base != st) fresh = 1'b1;
      chan[ch].base = st;
    end
    if (!(fresh || force_load)) return;
    if (mode == MODE_OFF || mode == MODE_ON) begin
      chan[ch].pos = 5'd0;
      chan[ch].ticks = 8'd0;
      chan[ch].level = (mode == MODE_ON);
    end else begin
      chan[ch].pos = 5'd1;
      chan[ch].ticks = pattern_byte(ch, st, 5'd1);
      chan[ch].level = 1'b0;
    end
  endfunction

  function automatic void step_channel(input int ch);
    logic [4:0] cur;
    byte_t nxt;
    if (chan[ch].pos == 5'd0) return;
    cur = (chan[ch].overlay != 5'd0) ? chan[ch].overlay : chan[ch].base;
    if (cur == 5'd0) return;
    chan[ch].ticks = chan[ch].ticks - 8'd1;
    if (chan[ch].ticks != 8'd0) return;
    chan[ch].pos = chan[ch].pos + 5'd1;
    nxt = pattern_byte(ch, cur, chan[ch].pos);
    if (nxt == MARK_END) begin
      // pattern over: once overlay goes away, base restarts from the top
      chan[ch].overlay = 5'd0;
      load_status(ch, chan[ch].base, 1'b1);
    end else begin
      chan[ch].ticks = nxt;
      chan[ch].level = ~chan[ch].pos[0];  // odd slots dark, even slots lit
    end
  endfunction

  // Applies one beat to the predictor and returns the levels it leaves.
  function automatic levels_t next_levels(input logic c, input logic [4:0] st);
    levels_t lv;
    if (!c) begin
      prescale_q = prescale_q + 8'd1;
      if (prescale_q >= divide_q) begin  // divider of zero steps on every tick
        prescale_q = 8'd0;
        step_channel(0);
        step_channel(1);
      end
    end else begin
      if (int'(st) < STATUS_TOTAL) begin
        load_status(0, st, 1'b0);
        load_status(1, st, 1'b0);
      end
      prescale_q = 8'd0;
    end
    lv.led = chan[0].level;
    lv.buz = chan[1].level;
    return lv;
  endfunction

  // Status code for a random set beat; permanent codes lock the base, so
  // they only appear where the phase allows them.
  function automatic logic [4:0] pick_code(input bit allow_perm);
    int r;
    logic [4:0] st;
    r = $urandom_range(0, 99);
    if (allow_perm && r < 30) begin
      r = $urandom_range(0, 4);
      st = (r == 4) ? 5'd20 : 5'(15 + r);
    end else if (r < 40) begin
      st = 5'($urandom_range(0, 31));
    end else if (r < 48) begin
      st = 5'd0;
    end else begin
      st = 5'($urandom_range(1, 15));
      if (st == 5'd15) st = 5'd19;
    end
    if (!allow_perm && pattern_byte(0, st, 5'd0) == MODE_PERMANENT)
      st = 5'($urandom_range(1, 14));
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a segment pattern of its own - always ready,
  // coin flip, mostly stalled, or toggling - each segment of random length.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(4, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ch.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ch.ready <= ~out_ch.ready;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output checker: every accepted beat is compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    levels_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_levels.size() == 0) begin
        $error("output beat with no expected levels: led_on %b buzzer_on %b",
               out_ch.led_on, out_ch.buzzer_on);
        failed = 1'b1;
      end else begin
        want = pending_levels.pop_front();
        if (out_ch.led_on !== want.led) begin
          $error("led_on: expected %b, got %b", want.led, out_ch.led_on);
          failed = 1'b1;
        end
        if (out_ch.buzzer_on !== want.buz) begin
          $error("buzzer_on: expected %b, got %b", want.buz, out_ch.buzzer_on);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int cycle_count = 0;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // Holds one beat on the input until it is taken, then records what it should
  // produce. valid is left high; callers lower it for a gap, a divider write or at the end.
  task automatic offer(input logic c, input logic [4:0] st, input bit typed,
                       input levels_t typed_lv);
    levels_t lv;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.status_code <= st;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    lv = next_levels(c, st);
    pending_levels.push_back(typed ? typed_lv : lv);
  endtask

  // Bursts of back-to-back beats, with a random gap (often none) between bursts.
  task automatic paced_offer(input logic c, input logic [4:0] st, input bit typed,
                             input levels_t typed_lv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    offer(c, st, typed, typed_lv);
  endtask

  // Divider write: only once the block has gone quiet.
  task automatic write_divide(input logic [7:0] value);
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    divide_q = value;
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed script. Rows marked typed carry levels that are obvious by
  // inspection; the rest take the predictor's answer.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {DO_TICK, DO_STATUS, DO_DIVIDE} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] value;
    bit         typed;
    logic       led;
    logic       buz;
  } script_row_t;

  localparam int SCRIPT_ROWS = 25;

  script_row_t script [SCRIPT_ROWS] = '{
    '{DO_TICK,   8'd0,   1'b1, 1'b0, 1'b0},  // out of reset: both dark
    '{DO_STATUS, 8'd13,  1'b1, 1'b1, 1'b0},  // LED steady on, buzzer off
    '{DO_STATUS, 8'd31,  1'b1, 1'b1, 1'b0},  // top code, out of range: no change
    '{DO_STATUS, 8'd21,  1'b1, 1'b1, 1'b0},  // first code out of range
    '{DO_STATUS, 8'd0,   1'b1, 1'b1, 1'b0},  // none: levels hold
    '{DO_DIVIDE, 8'd0,   1'b0, 1'b0, 1'b0},  // divider zero acts as one
    '{DO_STATUS, 8'd2,   1'b1, 1'b0, 1'b0},  // once pattern starts dark
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},  // buzzer once ends, no base: holds
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_STATUS, 8'd9,   1'b0, 1'b0, 1'b0},  // repeat goes under the LED overlay
    '{DO_STATUS, 8'd19,  1'b0, 1'b0, 1'b0},  // new once replaces the overlay
    '{DO_DIVIDE, 8'd255, 1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_STATUS, 8'd11,  1'b0, 1'b0, 1'b0},  // longest pattern
    '{DO_DIVIDE, 8'd1,   1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0},
    '{DO_STATUS, 8'd12,  1'b0, 1'b0, 1'b0},
    '{DO_TICK,   8'd0,   1'b0, 1'b0, 1'b0}
  };

  // Random phases: divider, beat count, percent of set beats, permanent codes.
  // Permanent codes lock the base for good, so they come last.
  typedef struct {
    logic [7:0] divide;
    int         beats;
    int         status_pct;
    bit         perm;
  } phase_t;

  localparam int PHASES = 6;

  phase_t plan [PHASES] = '{
    '{8'd1,   240, 8,  1'b0},
    '{8'd0,   150, 6,  1'b0},
    '{8'd3,   200, 10, 1'b0},
    '{8'd5,   100, 4,  1'b0},
    '{8'd255, 300, 0,  1'b0},  // long enough for one full prescaler period
    '{8'd1,   260, 8,  1'b1}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    levels_t lv;
    logic c;
    logic [4:0] st;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.status_code = 5'd0;
    out_ch.ready = 1'b0;
    failed = 1'b0;

    // predictor reset
    divide_q = DIVIDE_AT_RESET;
    prescale_q = 8'd0;
    for (int ch = 0; ch < 2; ch++) begin
      chan[ch].base = 5'd0;
      chan[ch].overlay = 5'd0;
      chan[ch].pos = 5'd0;
      chan[ch].ticks = 8'd0;
      chan[ch].level = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      lv.led = script[i].led;
      lv.buz = script[i].buz;
      case (script[i].kind)
        DO_DIVIDE: begin
          write_divide(script[i].value);
        end
        DO_STATUS: begin
          paced_offer(1'b1, script[i].value[4:0], script[i].typed, lv);
        end
        default: begin
          // status field is a don't-care on a tick; keep it moving
          paced_offer(1'b0, 5'($urandom_range(0, 31)), script[i].typed, lv);
        end
      endcase
    end

    lv = '0;
    for (int p = 0; p < PHASES; p++) begin
      write_divide(plan[p].divide);
      for (int n = 0; n < plan[p].beats; n++) begin
        if ($urandom_range(0, 99) < plan[p].status_pct) begin
          c = 1'b1;
          st = pick_code(plan[p].perm);
        end else begin
          c = 1'b0;
          st = 5'($urandom_range(0, 31));
        end
        paced_offer(c, st, 1'b0, lv);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
